// ===== rtl/core/tclp_pkg.sv =====
// Package for the text command line parser: types, token tables and helpers.
`timescale 1ns / 1ps

package tclp_pkg;

    // Longest token that the position counter follows before it saturates
    localparam int MAX_TOKEN_LEN_DEF = 16;
    // Result queue depth (entries)
    localparam int FIFO_DEPTH = 8;

    // Special characters
    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    // Result kinds
    localparam logic [1:0] KIND_INSTR = 2'd0;
    localparam logic [1:0] KIND_WORD  = 2'd1;
    localparam logic [1:0] KIND_HEX   = 2'd2;
    localparam logic [1:0] KIND_EOL   = 2'd3;

    // End of line codes
    localparam logic [2:0] EOL_RECOG   = 3'd0;
    localparam logic [2:0] EOL_IGNORED = 3'd1;

    // Token tables, 16 characters each, first character in the top byte.
    // Padding past the token length is never compared.
    localparam logic [127:0] INSTR_TXT [2] = '{"set.information ", "set.status      "};
    localparam logic [3:0]   INSTR_LEN [2] = '{4'd15, 4'd10};
    localparam logic [127:0] NAME_TXT  [6] = '{"key             ", "of              ",
                                               "index           ", "pressed         ",
                                               "sounding        ", "value           "};
    localparam logic [3:0]   NAME_LEN  [6] = '{4'd3, 4'd2, 4'd5, 4'd7, 4'd8, 4'd5};
    localparam logic [127:0] WORD_TXT  [3] = '{"string          ", "string count    ",
                                               "position range  "};
    localparam logic [3:0]   WORD_LEN  [3] = '{4'd6, 4'd12, 4'd14};

    typedef enum logic [2:0] {
        PH_WAIT_INSTR,
        PH_INSTR,
        PH_WAIT_NAME,
        PH_NAME,
        PH_WAIT_EQ,
        PH_WAIT_QUOTE,
        PH_VALUE,
        PH_DROP
    } t_phase;

    typedef enum logic [1:0] {
        LS_ACTIVE,
        LS_RECOG,
        LS_IGNORED
    } t_line_status;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  code;
        logic [31:0] value;
        logic        last;
    } t_result;

    // Up to two results written per character, first one in slot 0
    typedef struct packed {
        logic    v0;
        t_result d0;
        logic    v1;
        t_result d1;
    } t_push;

    // Character k of a table entry
    function automatic logic [7:0] tbl_char(input logic [127:0] s, input logic [3:0] k);
        logic [6:0] base;
        base = {~k, 3'b000};
        return s[base +: 8];
    endfunction

    // Index of the lowest set bit, zero when none
    function automatic logic [2:0] first_idx(input logic [5:0] m);
        logic [2:0] idx;
        idx = 3'd0;
        for (int i = 5; i >= 0; i--) begin
            if (m[i]) idx = 3'(i);
        end
        return idx;
    endfunction

endpackage

// ===== rtl/core/tclp_if.sv =====
// Valid/ready channel interfaces for the parser input and result streams.
`timescale 1ns / 1ps

interface tclp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

interface tclp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [2:0]  code;
    logic [31:0] value;
    logic        last;
    modport source (output valid, output kind, output code, output value, output last,
                    input ready);
    modport sink   (input valid, input kind, input code, input value, input last,
                    output ready);
endinterface

// ===== rtl/core/tclp_parse.sv =====
// Per-character parse step: line state, token matching and result generation.
`timescale 1ns / 1ps

module tclp_parse
    import tclp_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_char,
    output t_push      o_push
);

    localparam int POS_W = $clog2(MAX_TOKEN_LEN + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_TOKEN_LEN);

    t_phase           r_phase, n_phase;
    t_line_status     r_ls, n_ls;
    logic [1:0]       r_instr, n_instr;
    logic [5:0]       r_name, n_name;
    logic [2:0]       r_word, n_word;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [31:0]      r_hex, n_hex;
    logic             r_hex_ok, n_hex_ok;
    logic             r_esc, n_esc;

    // Per-candidate match of this character and exact-length test
    logic [1:0] instr_hit, instr_exact;
    logic [5:0] name_hit, name_exact;
    logic [2:0] word_hit, word_exact;
    logic [3:0] pos_lo;

    assign pos_lo = r_pos[3:0];

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            instr_hit[i] = (r_pos < POS_W'(INSTR_LEN[i])) &&
                           (tbl_char(INSTR_TXT[i], pos_lo) == i_char);
            instr_exact[i] = r_instr[i] && (r_pos == POS_W'(INSTR_LEN[i]));
        end
        for (int i = 0; i < 6; i++) begin
            name_hit[i] = (r_pos < POS_W'(NAME_LEN[i])) &&
                          (tbl_char(NAME_TXT[i], pos_lo) == i_char);
            name_exact[i] = r_name[i] && (r_pos == POS_W'(NAME_LEN[i]));
        end
        for (int i = 0; i < 3; i++) begin
            word_hit[i] = (r_pos < POS_W'(WORD_LEN[i])) &&
                          (tbl_char(WORD_TXT[i], pos_lo) == i_char);
            word_exact[i] = r_word[i] && (r_pos == POS_W'(WORD_LEN[i]));
        end
    end

    // Saturating position step
    logic [POS_W-1:0] pos_inc;
    assign pos_inc = (r_pos < POS_MAX) ? r_pos + 1'b1 : r_pos;

    // Hex digit decode
    logic       is_hex;
    logic [3:0] hex_digit;
    always_comb begin
        is_hex    = 1'b1;
        hex_digit = 4'd0;
        if (i_char >= "0" && i_char <= "9") begin
            hex_digit = 4'(i_char - "0");
        end else if (i_char >= "a" && i_char <= "f") begin
            hex_digit = 4'(i_char - "a" + 8'd10);
        end else if (i_char >= "A" && i_char <= "F") begin
            hex_digit = 4'(i_char - "A" + 8'd10);
        end else begin
            is_hex = 1'b0;
        end
    end

    // Result that closing the current value would give
    logic    close_v;
    t_result close_res;
    always_comb begin
        close_v   = 1'b0;
        close_res = '0;
        if (r_name[1:0] != 2'b00) begin
            close_v         = (word_exact != 3'b000);
            close_res.kind  = KIND_WORD;
            close_res.code  = first_idx(r_name);
            close_res.value = {29'd0, first_idx({3'b000, word_exact})};
        end else if (r_name != 6'd0) begin
            close_v         = 1'b1;
            close_res.kind  = KIND_HEX;
            close_res.code  = first_idx(r_name);
            close_res.value = r_hex;
        end
    end

    // Next state and results
    logic         is_end;
    logic         p_v;
    t_result      p_res;
    t_line_status ls_end;
    assign is_end = (i_char == CH_LF) || (i_char == CH_CR);

    always_comb begin
        n_phase  = r_phase;
        n_ls     = r_ls;
        n_instr  = r_instr;
        n_name   = r_name;
        n_word   = r_word;
        n_pos    = r_pos;
        n_hex    = r_hex;
        n_hex_ok = r_hex_ok;
        n_esc    = r_esc;
        p_v      = 1'b0;
        p_res    = '0;
        ls_end   = r_ls;
        o_push   = '0;

        if (i_valid && is_end) begin
            if (r_phase == PH_INSTR) begin
                if (instr_exact != 2'b00) begin
                    p_v        = 1'b1;
                    p_res.kind = KIND_INSTR;
                    p_res.code = first_idx({4'b0000, instr_exact});
                    ls_end     = LS_RECOG;
                end else begin
                    ls_end = LS_IGNORED;
                end
            end else if (r_phase == PH_VALUE) begin
                p_v   = close_v;
                p_res = close_res;
            end
            // Whole line state goes back to its start values
            n_phase  = PH_WAIT_INSTR;
            n_ls     = LS_ACTIVE;
            n_instr  = 2'b11;
            n_name   = 6'h3F;
            n_word   = 3'b111;
            n_pos    = '0;
            n_hex    = '0;
            n_hex_ok = 1'b1;
            n_esc    = 1'b0;
        end else if (i_valid) begin
            case (r_phase)
                PH_WAIT_INSTR, PH_INSTR: begin
                    if (i_char == CH_SPACE) begin
                        if (r_phase == PH_INSTR) begin
                            n_instr = instr_exact;
                            n_pos   = '0;
                            if (instr_exact != 2'b00) begin
                                p_v        = 1'b1;
                                p_res.kind = KIND_INSTR;
                                p_res.code = first_idx({4'b0000, instr_exact});
                                n_ls       = LS_RECOG;
                                n_phase    = PH_WAIT_NAME;
                            end else begin
                                n_ls    = LS_IGNORED;
                                n_phase = PH_DROP;
                            end
                        end
                    end else begin
                        n_phase = PH_INSTR;
                        n_instr = r_instr & instr_hit;
                        n_pos   = pos_inc;
                    end
                end
                PH_WAIT_NAME, PH_NAME: begin
                    if (i_char == CH_EQ) begin
                        n_name  = name_exact;
                        n_pos   = '0;
                        n_phase = PH_WAIT_QUOTE;
                    end else if (i_char == CH_SPACE) begin
                        if (r_phase == PH_NAME) begin
                            n_name  = name_exact;
                            n_pos   = '0;
                            n_phase = PH_WAIT_EQ;
                        end
                    end else begin
                        n_phase = PH_NAME;
                        n_name  = r_name & name_hit;
                        n_pos   = pos_inc;
                    end
                end
                PH_WAIT_EQ: begin
                    if (i_char != CH_SPACE) begin
                        n_phase = (i_char == CH_EQ) ? PH_WAIT_QUOTE : PH_DROP;
                    end
                end
                PH_WAIT_QUOTE: begin
                    if (i_char == CH_QUOTE) begin
                        n_phase  = PH_VALUE;
                        n_word   = 3'b111;
                        n_pos    = '0;
                        n_hex    = '0;
                        n_hex_ok = 1'b1;
                        n_esc    = 1'b0;
                    end else if (i_char != CH_SPACE) begin
                        n_phase = PH_DROP;
                    end
                end
                PH_VALUE: begin
                    if (!r_esc && i_char == CH_BSLASH) begin
                        n_esc = 1'b1;
                    end else if (!r_esc && i_char == CH_QUOTE) begin
                        p_v      = close_v;
                        p_res    = close_res;
                        n_name   = 6'h3F;
                        n_word   = 3'b111;
                        n_pos    = '0;
                        n_hex    = '0;
                        n_hex_ok = 1'b1;
                        n_esc    = 1'b0;
                        n_phase  = PH_WAIT_NAME;
                    end else begin
                        // ordinary or escaped character inside the value
                        n_esc  = 1'b0;
                        n_word = r_word & word_hit;
                        n_pos  = pos_inc;
                        if (r_hex_ok) begin
                            if (is_hex) n_hex = {r_hex[27:0], hex_digit};
                            else        n_hex_ok = 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        // Pack results: optional token result, then end of line
        if (i_valid && is_end) begin
            if (p_v) begin
                o_push.v0      = 1'b1;
                o_push.d0      = p_res;
                o_push.d0.last = 1'b0;
                o_push.v1      = 1'b1;
                o_push.d1.kind = KIND_EOL;
                o_push.d1.code = (ls_end == LS_RECOG) ? EOL_RECOG : EOL_IGNORED;
                o_push.d1.last = 1'b1;
            end else begin
                o_push.v0      = 1'b1;
                o_push.d0.kind = KIND_EOL;
                o_push.d0.code = (ls_end == LS_RECOG) ? EOL_RECOG : EOL_IGNORED;
                o_push.d0.last = 1'b1;
            end
        end else if (p_v) begin
            o_push.v0      = 1'b1;
            o_push.d0      = p_res;
            o_push.d0.last = 1'b1;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_WAIT_INSTR;
            r_ls     <= LS_ACTIVE;
            r_instr  <= 2'b11;
            r_name   <= 6'h3F;
            r_word   <= 3'b111;
            r_pos    <= '0;
            r_hex    <= '0;
            r_hex_ok <= 1'b1;
            r_esc    <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_ls     <= n_ls;
            r_instr  <= n_instr;
            r_name   <= n_name;
            r_word   <= n_word;
            r_pos    <= n_pos;
            r_hex    <= n_hex;
            r_hex_ok <= n_hex_ok;
            r_esc    <= n_esc;
        end
    end

endmodule

// ===== rtl/core/tclp_fifo.sv =====
// Result queue: takes up to two items per cycle, delivers one per cycle while i_pop is high.
`timescale 1ns / 1ps

module tclp_fifo
    import tclp_pkg::*;
(
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  t_push                           i_push,
    input  logic                            i_pop,
    output logic                            o_valid,
    output t_result                         o_data,
    output logic [$clog2(FIFO_DEPTH+1)-1:0] o_count
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    t_result          r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;
    logic             do_pop;
    logic [1:0]       n_push;
    logic [PTR_W-1:0] wr_ptr1;

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_cnt;
    assign do_pop  = i_pop && o_valid;
    assign n_push  = {1'b0, i_push.v0} + {1'b0, i_push.v1};
    assign wr_ptr1 = r_wr_ptr + 1'b1;

    // Storage writes
    always_ff @(posedge i_clk) begin
        if (i_push.v0) r_mem[r_wr_ptr] <= i_push.d0;
        if (i_push.v1) r_mem[wr_ptr1]  <= i_push.d1;
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(n_push);
            if (do_pop) r_rd_ptr <= r_rd_ptr + 1'b1;
            r_cnt <= r_cnt + CNT_W'(n_push) - CNT_W'(do_pop);
        end
    end

endmodule

// ===== rtl/core/text_command_line_parser.sv =====
// Top level of the text command line parser.
`timescale 1ns / 1ps

// Takes one received byte per item on i_in and reports instructions, parameters
// and line ends on o_out. An accepted byte is held in an input register and
// parsed in the next cycle, which writes up to two results for it into an
// eight-entry result queue; one byte can be accepted every cycle while the
// queue has room for two more results beyond those already on their way.
// Results leave the queue at one per cycle while o_out.ready is high, so a byte
// that yields two results (a line end that also closes a token) delivers them
// one after the other.
module text_command_line_parser
    import tclp_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tclp_in_if.sink           i_in,
    tclp_out_if.source        o_out
);

    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    logic             r_in_valid;
    logic [7:0]       r_in_char;
    t_push            push;
    t_result          head;
    logic [CNT_W-1:0] fifo_cnt;
    logic [CNT_W:0]   committed;
    logic             in_ready;

    // Room check: queued results plus two for the registered byte and two for a new one
    assign committed = {1'b0, fifo_cnt} + (r_in_valid ? (CNT_W+1)'(2) : '0);
    assign in_ready  = (committed <= (CNT_W+1)'(FIFO_DEPTH - 2));
    assign i_in.ready = in_ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_in.valid && in_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && in_ready) r_in_char <= i_in.char_in;
    end

    tclp_parse #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
    ) u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_char  (r_in_char),
        .o_push  (push)
    );

    tclp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (o_out.ready),
        .o_valid (o_out.valid),
        .o_data  (head),
        .o_count (fifo_cnt)
    );

    assign o_out.kind  = head.kind;
    assign o_out.code  = head.code;
    assign o_out.value = head.value;
    assign o_out.last  = head.last;

endmodule
